[rtl/jdc_pkg.sv]
// jdc_pkg: shared types, constants and tables of the julian day converter
package jdc_pkg;

  localparam int NSTAGE   = 10;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int JDN_W    = 23;
  localparam int TDATA_W  = 48;

  typedef enum logic {
    OP_DATE_TO_JDN = 1'b0,
    OP_JDN_TO_DATE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] vld;
  } pipe_ctl_t;

  localparam logic [22:0] JDN_EPOCH     = 23'd1721119;
  localparam logic [22:0] JDN_FIRST     = 23'd1721426;
  localparam logic [22:0] JDN_LAST      = 23'd5373484;
  localparam logic [17:0] DAYS_400Y     = 18'd146097;
  localparam logic [10:0] DAYS_4Y       = 11'd1461;
  localparam logic [7:0]  MONTH_SPAN    = 8'd153;
  localparam logic [6:0]  YEARS_CENTURY = 7'd100;

  // reciprocals, floor(2^s / divisor); quotient is exact or one low
  localparam logic [12:0] RCP_CENT  = 13'd5242;   // 2^19 / 100
  localparam logic [13:0] RCP_400Y  = 14'd14699;  // 2^31 / 146097
  localparam logic [13:0] RCP_4Y    = 14'd11483;  // 2^24 / 1461
  localparam logic [8:0]  RCP_MSPAN = 9'd428;     // 2^16 / 153
  // rounded up, exact for the small values divided by five
  localparam logic [7:0]  RCP_FIVE  = 8'd205;     // 2^10 / 5

  // (153 * m + 2) / 5, days before march-based month m
  function automatic logic [8:0] month_days(input logic [3:0] m);
    logic [8:0] res;
    unique case (m)
      4'd0:  res = 9'd0;
      4'd1:  res = 9'd31;
      4'd2:  res = 9'd61;
      4'd3:  res = 9'd92;
      4'd4:  res = 9'd122;
      4'd5:  res = 9'd153;
      4'd6:  res = 9'd184;
      4'd7:  res = 9'd214;
      4'd8:  res = 9'd245;
      4'd9:  res = 9'd275;
      4'd10: res = 9'd306;
      4'd11: res = 9'd337;
      4'd12: res = 9'd367;
      4'd13: res = 9'd398;
      4'd14: res = 9'd428;
      4'd15: res = 9'd459;
    endcase
    return res;
  endfunction

endpackage

[rtl/jdc_ctrl.sv]
// jdc_ctrl: valid bits and stage enables of the conversion pipeline
module jdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                out_tready,
  output jdc_pkg::pipe_ctl_t  ctl
);
  import jdc_pkg::*;

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] en_c;

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    en_c[NSTAGE-1] = ~vld_r[NSTAGE-1] | out_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en_c[i] = ~vld_r[i] | en_c[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en_c[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en_c[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  assign ctl.en  = en_c;
  assign ctl.vld = vld_r;

endmodule

[rtl/jdc_fwd.sv]
// jdc_fwd: date to julian day number datapath
module jdc_fwd (
  input  logic                               clk,
  input  jdc_pkg::pipe_ctl_t                 ctl,
  input  jdc_pkg::opcode_t                   op,
  input  logic [jdc_pkg::YEAR_W-1:0]         year,
  input  logic [jdc_pkg::MONTH_W-1:0]        month,
  input  logic [jdc_pkg::DAY_W-1:0]          day,
  output logic [jdc_pkg::JDN_W-1:0]          day_number_out
);
  import jdc_pkg::*;

  // stage 0: clamp and march-based month
  logic [YEAR_W-1:0]  y_clamp;
  logic [YEAR_W-1:0]  y0_nxt, y0_r;
  logic [MONTH_W-1:0] m0_nxt, m0_r;
  logic [DAY_W-1:0]   d0_r;
  opcode_t            op0_r;

  // stage 1: century estimate
  logic [26:0]        cq_prod;
  logic [7:0]         q1_r;
  logic [YEAR_W-1:0]  y1_r;
  logic [MONTH_W-1:0] m1_r;
  logic [DAY_W-1:0]   d1_r;
  opcode_t            op1_r;

  // stage 2: century and year of century
  logic [14:0]        cr_diff;
  logic [7:0]         cent2_nxt, cent2_r;
  logic [6:0]         cy2_nxt, cy2_r;
  logic [MONTH_W-1:0] m2_r;
  logic [DAY_W-1:0]   d2_r;
  opcode_t            op2_r;

  // stage 3: partial day counts
  logic [25:0]        a_prod;
  logic [17:0]        b_prod;
  logic [23:0]        a3_r;
  logic [15:0]        b3_r;
  logic [8:0]         c3_r;
  logic [DAY_W-1:0]   d3_r;
  opcode_t            op3_r;

  // stage 4: sum, then delay to the end of the pipeline
  logic [23:0]        sum4;
  logic [JDN_W-1:0]   jdn4_nxt;
  logic [JDN_W-1:0]   jdn_r [4:NSTAGE-1];

  always_comb begin
    y_clamp = (year == '0) ? YEAR_W'(1) : year;
    if (month > 4'd2) begin
      m0_nxt = month - 4'd3;
      y0_nxt = y_clamp;
    end else begin
      m0_nxt = month + 4'd9;
      y0_nxt = y_clamp - YEAR_W'(1);
    end
  end

  assign cq_prod = 27'(y0_r) * 27'(RCP_CENT);
  assign cr_diff = 15'(y1_r) - 15'(q1_r) * 15'(YEARS_CENTURY);

  always_comb begin
    if (cr_diff >= 15'(YEARS_CENTURY)) begin
      cent2_nxt = q1_r + 8'd1;
      cy2_nxt   = 7'(cr_diff - 15'(YEARS_CENTURY));
    end else begin
      cent2_nxt = q1_r;
      cy2_nxt   = 7'(cr_diff);
    end
  end

  assign a_prod = 26'(DAYS_400Y) * 26'(cent2_r);
  assign b_prod = 18'(DAYS_4Y) * 18'(cy2_r);

  assign sum4 = 24'(a3_r) + 24'(b3_r) + 24'(c3_r) + 24'(d3_r) + 24'(JDN_EPOCH);
  assign jdn4_nxt = (op3_r == OP_JDN_TO_DATE) ? '0 : sum4[JDN_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      y0_r  <= y0_nxt;
      m0_r  <= m0_nxt;
      d0_r  <= day;
      op0_r <= op;
    end
    if (ctl.en[1]) begin
      q1_r  <= cq_prod[26:19];
      y1_r  <= y0_r;
      m1_r  <= m0_r;
      d1_r  <= d0_r;
      op1_r <= op0_r;
    end
    if (ctl.en[2]) begin
      cent2_r <= cent2_nxt;
      cy2_r   <= cy2_nxt;
      m2_r    <= m1_r;
      d2_r    <= d1_r;
      op2_r   <= op1_r;
    end
    if (ctl.en[3]) begin
      a3_r  <= a_prod[25:2];
      b3_r  <= b_prod[17:2];
      c3_r  <= month_days(m2_r);
      d3_r  <= d2_r;
      op3_r <= op2_r;
    end
    if (ctl.en[4]) begin
      jdn_r[4] <= jdn4_nxt;
    end
    for (int i = 5; i < NSTAGE; i++) begin
      if (ctl.en[i]) begin
        jdn_r[i] <= jdn_r[i-1];
      end
    end
  end

  assign day_number_out = jdn_r[NSTAGE-1];

endmodule

[rtl/jdc_inv.sv]
// jdc_inv: julian day number to date datapath with range check
module jdc_inv (
  input  logic                               clk,
  input  jdc_pkg::pipe_ctl_t                 ctl,
  input  jdc_pkg::opcode_t                   op,
  input  logic [jdc_pkg::JDN_W-1:0]          day_number,
  output logic [jdc_pkg::YEAR_W-1:0]         out_year,
  output logic [jdc_pkg::MONTH_W-1:0]        out_month,
  output logic [jdc_pkg::DAY_W-1:0]          out_day,
  output logic                               range_error
);
  import jdc_pkg::*;

  opcode_t     op_r  [0:NSTAGE-2];
  logic        err_r [0:NSTAGE-2];
  logic [6:0]  cent_r [3:NSTAGE-2];
  logic [7:0]  yc_r   [6:NSTAGE-2];

  // stage 0
  logic [JDN_W-1:0] t_full;
  logic [23:0]      x0_nxt, x0_r;
  logic             err0_nxt;
  // stage 1
  logic [37:0]      p1;
  logic [6:0]       q1_r;
  logic [23:0]      x1_r;
  // stage 2
  logic [24:0]      prod2, diff2;
  logic [18:0]      r2_r;
  logic [6:0]       q2_r;
  // stage 3
  logic [18:0]      rr3;
  logic [6:0]       cent3_nxt;
  logic [17:0]      x3_r;
  // stage 4
  logic [31:0]      p4;
  logic [7:0]       q4_r;
  logic [17:0]      x4_r;
  // stage 5
  logic [18:0]      prod5, diff5;
  logic [11:0]      r5_r;
  logic [7:0]       q5_r;
  // stage 6
  logic [11:0]      d6;
  logic [7:0]       yc6_nxt;
  logic [8:0]       d6b;
  logic [11:0]      x6_full;
  logic [10:0]      x6_r;
  // stage 7
  logic [19:0]      p7;
  logic [3:0]       q7_r;
  logic [10:0]      x7_r;
  // stage 8
  logic [11:0]      prod8, diff8;
  logic [8:0]       r8;
  logic [3:0]       m8_nxt, m8_r;
  logic [7:0]       d8_nxt, d8_r;
  // stage 9
  logic [8:0]       d9s;
  logic [16:0]      dprod9;
  logic [YEAR_W-1:0]  year9;
  logic [MONTH_W-1:0] month9;
  logic             late9;
  logic             keep9;
  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [DAY_W-1:0]   day_r;
  logic             err_o_r;

  assign t_full   = day_number - JDN_EPOCH;
  assign x0_nxt   = {t_full[21:0], 2'b00} - 24'd1;
  assign err0_nxt = (day_number < JDN_FIRST) || (day_number > JDN_LAST);

  assign p1 = 38'(x0_r) * 38'(RCP_400Y);

  assign prod2 = 25'(DAYS_400Y) * 25'(q1_r);
  assign diff2 = 25'(x1_r) - prod2;

  always_comb begin
    if (r2_r >= 19'(DAYS_400Y)) begin
      cent3_nxt = q2_r + 7'd1;
      rr3       = r2_r - 19'(DAYS_400Y);
    end else begin
      cent3_nxt = q2_r;
      rr3       = r2_r;
    end
  end

  assign p4 = 32'(x3_r) * 32'(RCP_4Y);

  assign prod5 = 19'(DAYS_4Y) * 19'(q4_r);
  assign diff5 = 19'(x4_r) - prod5;

  always_comb begin
    if (r5_r >= 12'(DAYS_4Y)) begin
      yc6_nxt = q5_r + 8'd1;
      d6      = r5_r - 12'(DAYS_4Y);
    end else begin
      yc6_nxt = q5_r;
      d6      = r5_r;
    end
    d6b     = d6[10:2] + 9'd1;
    x6_full = 12'(d6b) * 12'd5 - 12'd3;
  end

  assign p7 = 20'(x6_r) * 20'(RCP_MSPAN);

  assign prod8 = 12'(MONTH_SPAN) * 12'(q7_r);
  assign diff8 = 12'(x7_r) - prod8;
  assign r8    = diff8[8:0];

  always_comb begin
    if (r8 >= 9'(MONTH_SPAN)) begin
      m8_nxt = q7_r + 4'd1;
      d8_nxt = 8'(r8 - 9'(MONTH_SPAN));
    end else begin
      m8_nxt = q7_r;
      d8_nxt = r8[7:0];
    end
  end

  // march-based month back to calendar month, jan and feb close the year
  always_comb begin
    late9  = (m8_r >= 4'd10);
    month9 = late9 ? (m8_r - 4'd9) : (m8_r + 4'd3);
    year9  = YEAR_W'(cent_r[NSTAGE-2]) * YEAR_W'(YEARS_CENTURY)
           + YEAR_W'(yc_r[NSTAGE-2]) + YEAR_W'(late9);
    d9s    = 9'(d8_r) + 9'd5;
    dprod9 = 17'(d9s) * 17'(RCP_FIVE);
    keep9  = (op_r[NSTAGE-2] == OP_JDN_TO_DATE) && !err_r[NSTAGE-2];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      x0_r     <= x0_nxt;
      op_r[0]  <= op;
      err_r[0] <= err0_nxt;
    end
    for (int i = 1; i < NSTAGE - 1; i++) begin
      if (ctl.en[i]) begin
        op_r[i]  <= op_r[i-1];
        err_r[i] <= err_r[i-1];
      end
    end
    if (ctl.en[1]) begin
      q1_r <= p1[37:31];
      x1_r <= x0_r;
    end
    if (ctl.en[2]) begin
      r2_r <= diff2[18:0];
      q2_r <= q1_r;
    end
    if (ctl.en[3]) begin
      cent_r[3] <= cent3_nxt;
      x3_r      <= {rr3[17:2], 2'b11};
    end
    for (int i = 4; i < NSTAGE - 1; i++) begin
      if (ctl.en[i]) begin
        cent_r[i] <= cent_r[i-1];
      end
    end
    if (ctl.en[4]) begin
      q4_r <= p4[31:24];
      x4_r <= x3_r;
    end
    if (ctl.en[5]) begin
      r5_r <= diff5[11:0];
      q5_r <= q4_r;
    end
    if (ctl.en[6]) begin
      yc_r[6] <= yc6_nxt;
      x6_r    <= x6_full[10:0];
    end
    for (int i = 7; i < NSTAGE - 1; i++) begin
      if (ctl.en[i]) begin
        yc_r[i] <= yc_r[i-1];
      end
    end
    if (ctl.en[7]) begin
      q7_r <= p7[19:16];
      x7_r <= x6_r;
    end
    if (ctl.en[8]) begin
      m8_r <= m8_nxt;
      d8_r <= d8_nxt;
    end
    if (ctl.en[NSTAGE-1]) begin
      year_r  <= keep9 ? year9 : '0;
      month_r <= keep9 ? month9 : '0;
      day_r   <= keep9 ? dprod9[14:10] : '0;
      err_o_r <= (op_r[NSTAGE-2] == OP_JDN_TO_DATE) && err_r[NSTAGE-2];
    end
  end

  assign out_year    = year_r;
  assign out_month   = month_r;
  assign out_day     = day_r;
  assign range_error = err_o_r;

endmodule

[rtl/julian_day_converter.sv]
// julian_day_converter: top level of the gregorian date / julian day number converter
// Input channel in_*: one item per handshake. in_tuser is the opcode, 0 turns
// year, month and day into a julian day number, 1 turns a day number into a
// date. Output channel out_*: one result item for every input item, in order.
// A day number outside years 1 to 9999 raises out_tuser (range error) and
// gives a zero date; fields that do not belong to the opcode read zero.
// The datapath is a 10-stage pipeline with a valid bit per stage, so one item
// can be taken in every cycle while the output accepts results. The longest
// stages hold one constant reciprocal multiply or a multiply, subtract and
// correcting compare of a constant division.
// When out_tready is low the last stage holds its result; earlier stages keep
// filling empty slots, and in_tready drops only once every stage is full.
// No item is lost or repeated across a stall.
// Reset (rst_n low, synchronous) clears the valid bits only; the block keeps
// no other state and is ready for an item in the cycle after reset.
module julian_day_converter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // year[13:0], month[17:14], day[22:18], day_number[45:23], zero[47:46]
  input  logic [jdc_pkg::TDATA_W-1:0]  in_tdata,
  // opcode[0]
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // day_number_out[22:0], year[36:23], month[40:37], day[45:41], zero[47:46]
  output logic [jdc_pkg::TDATA_W-1:0]  out_tdata,
  // range_error[0]
  output logic                         out_tuser
);
  import jdc_pkg::*;

  pipe_ctl_t          ctl;
  opcode_t            op;
  logic [JDN_W-1:0]   jdn_fwd;
  logic [YEAR_W-1:0]  year_inv;
  logic [MONTH_W-1:0] month_inv;
  logic [DAY_W-1:0]   day_inv;
  logic               err_inv;

  assign op = opcode_t'(in_tuser);

  jdc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  jdc_fwd u_fwd (
    .clk            (clk),
    .ctl            (ctl),
    .op             (op),
    .year           (in_tdata[13:0]),
    .month          (in_tdata[17:14]),
    .day            (in_tdata[22:18]),
    .day_number_out (jdn_fwd)
  );

  jdc_inv u_inv (
    .clk         (clk),
    .ctl         (ctl),
    .op          (op),
    .day_number  (in_tdata[45:23]),
    .out_year    (year_inv),
    .out_month   (month_inv),
    .out_day     (day_inv),
    .range_error (err_inv)
  );

  assign in_tready  = ctl.en[0];
  assign out_tvalid = ctl.vld[NSTAGE-1];
  assign out_tdata  = {2'b00, day_inv, month_inv, year_inv, jdn_fwd};
  assign out_tuser  = err_inv;

endmodule

[test/tb_julian_day_converter.sv]
`timescale 1ns / 100ps
// tb_julian_day_converter: self-checking stream testbench of the date / julian day converter
module tb_julian_day_converter;
  import jdc_pkg::*;

  localparam int unsigned EPOCH_DAY   = 1721119;
  localparam int unsigned FIRST_DAY   = 1721426;
  localparam int unsigned LAST_DAY    = 5373484;
  localparam int unsigned ERA_DAYS    = 146097;
  localparam int unsigned QUAD_DAYS   = 1461;
  localparam int unsigned FIVE_MONTHS = 153;
  localparam int unsigned CENTURY     = 100;
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_EVERY  = 150;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 4 * NSTAGE;

  typedef struct {
    opcode_t            op;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [JDN_W-1:0]   jdn;
    bit                 drain_first;
  } conv_req_t;

  typedef struct {
    logic [JDN_W-1:0]   jdn;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               range_error;
  } conv_res_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;
  logic                out_tuser;

  conv_req_t calendar_requests_q[$];
  conv_res_t calendar_results_q[$];

  int        fail_count   = 0;
  int        idle_cycles  = 0;
  bit        item_taken   = 1'b0;
  int        burst_left   = 0;
  int        gap_left     = 0;
  bit        sender_calm  = 1'b0;
  int        ready_span   = 0;
  logic [15:0] ready_pat  = '1;

  julian_day_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic conv_res_t convert_calendar(conv_req_t r);
    conv_res_t   res;
    int unsigned y, m, d, cent, yc, t, rem, total;
    res = '{default: '0};
    if (r.op == OP_DATE_TO_JDN) begin
      y = (r.year == 0) ? 1 : r.year;
      m = r.month;
      d = r.day;
      if (m > 2) begin
        m = m - 3;
      end else begin
        m = m + 9;
        y = y - 1;
      end
      cent  = y / CENTURY;
      yc    = y - CENTURY * cent;
      total = (ERA_DAYS * cent) / 4 + (QUAD_DAYS * yc) / 4 + (FIVE_MONTHS * m + 2) / 5
            + d + EPOCH_DAY;
      res.jdn = total[JDN_W-1:0];
    end else if (r.jdn < FIRST_DAY || r.jdn > LAST_DAY) begin
      res.range_error = 1'b1;
    end else begin
      t    = r.jdn - EPOCH_DAY;
      cent = (4 * t - 1) / ERA_DAYS;
      rem  = 4 * t - 1 - ERA_DAYS * cent;
      d    = rem / 4;
      yc   = (4 * d + 3) / QUAD_DAYS;
      d    = 4 * d + 3 - QUAD_DAYS * yc;
      d    = (d + 4) / 4;
      m    = (5 * d - 3) / FIVE_MONTHS;
      d    = 5 * d - 3 - FIVE_MONTHS * m;
      d    = (d + 5) / 5;
      y    = CENTURY * cent + yc;
      if (m < 10) begin
        m = m + 3;
      end else begin
        m = m - 9;
        y = y + 1;
      end
      res.year  = y[YEAR_W-1:0];
      res.month = m[MONTH_W-1:0];
      res.day   = d[DAY_W-1:0];
    end
    return res;
  endfunction

  function automatic int unsigned jdn_of(int unsigned y, int unsigned m, int unsigned d);
    conv_req_t req;
    conv_res_t res;
    req.op          = OP_DATE_TO_JDN;
    req.year        = y[YEAR_W-1:0];
    req.month       = m[MONTH_W-1:0];
    req.day         = d[DAY_W-1:0];
    req.jdn         = '0;
    req.drain_first = 1'b0;
    res = convert_calendar(req);
    return res.jdn;
  endfunction

  task automatic queue_request(opcode_t op, int unsigned y, int unsigned m, int unsigned d,
                               int unsigned n, bit drain);
    conv_req_t req;
    req.op          = op;
    req.year        = y[YEAR_W-1:0];
    req.month       = m[MONTH_W-1:0];
    req.day         = d[DAY_W-1:0];
    req.jdn         = n[JDN_W-1:0];
    req.drain_first = drain;
    calendar_requests_q.push_back(req);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // sender: bursts of items with gaps, holds an item until it is taken
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !item_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (calendar_requests_q.size() == 0 ||
                   (calendar_requests_q[0].drain_first && calendar_results_q.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tuser  <= calendar_requests_q[0].op;
        in_tdata  <= {2'b00, calendar_requests_q[0].jdn, calendar_requests_q[0].day,
                      calendar_requests_q[0].month, calendar_requests_q[0].year};
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          if ($urandom_range(0, 5) == 0) sender_calm = !sender_calm;
          burst_left = $urandom_range(1, 16);
          gap_left   = sender_calm ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: rotating ready pattern, replaced by a new random one when its span runs out
  always @(negedge clk) begin
    if (ready_span == 0) begin
      ready_span = $urandom_range(20, 80);
      case ($urandom_range(0, 4))
        0:       ready_pat = '1;
        1:       ready_pat = 16'($urandom()) | 16'h0001;
        2:       ready_pat = 16'($urandom() & $urandom()) | 16'h0001;
        3:       ready_pat = 16'h0001;
        default: ready_pat = 16'($urandom() | $urandom());
      endcase
    end
    ready_span--;
    out_tready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[15:1]};
  end

  always @(posedge clk) begin : monitor
    conv_res_t want;
    item_taken = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (calendar_results_q.size() == 0) begin
          $error("result item with no conversion outstanding");
          fail_count++;
        end else begin
          want = calendar_results_q.pop_front();
          check_field("day_number_out", want.jdn, out_tdata[22:0]);
          check_field("out_year", want.year, out_tdata[36:23]);
          check_field("out_month", want.month, out_tdata[40:37]);
          check_field("out_day", want.day, out_tdata[45:41]);
          check_field("range_error", want.range_error, out_tuser);
        end
      end
      if (in_tvalid && in_tready) begin
        item_taken = 1'b1;
        calendar_results_q.push_back(convert_calendar(calendar_requests_q.pop_front()));
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned pick, n;
    bit          drain;

    // dates: clamped year zero, month zero and months past december, day zero, top year
    queue_request(OP_DATE_TO_JDN, 0, 1, 1, $urandom, 1'b0);
    queue_request(OP_DATE_TO_JDN, 1, 1, 1, $urandom, 1'b0);
    queue_request(OP_DATE_TO_JDN, 1, 3, 1, $urandom, 1'b0);
    queue_request(OP_DATE_TO_JDN, 9999, 12, 31, $urandom, 1'b0);
    queue_request(OP_DATE_TO_JDN, 16383, 15, 31, 0, 1'b0);
    queue_request(OP_DATE_TO_JDN, 0, 0, 0, 23'h7fffff, 1'b0);
    queue_request(OP_DATE_TO_JDN, 2000, 2, 29, $urandom, 1'b0);
    queue_request(OP_DATE_TO_JDN, 1900, 2, 29, $urandom, 1'b0);
    queue_request(OP_DATE_TO_JDN, 2000, 13, 5, $urandom, 1'b0);
    queue_request(OP_DATE_TO_JDN, 1999, 0, 15, $urandom, 1'b0);
    queue_request(OP_DATE_TO_JDN, 12345, 2, 0, $urandom, 1'b0);
    queue_request(OP_DATE_TO_JDN, 5000, 7, 31, $urandom, 1'b0);
    // day numbers: both edges of the valid span, zero and all ones, leap days
    queue_request(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, 0, 1'b0);
    queue_request(OP_JDN_TO_DATE, 16383, 15, 31, FIRST_DAY - 1, 1'b0);
    queue_request(OP_JDN_TO_DATE, 0, 0, 0, FIRST_DAY, 1'b0);
    queue_request(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, LAST_DAY, 1'b0);
    queue_request(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, LAST_DAY + 1, 1'b0);
    queue_request(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, 23'h7fffff, 1'b0);
    queue_request(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, jdn_of(2000, 2, 29), 1'b0);
    queue_request(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, jdn_of(2000, 3, 1), 1'b0);
    queue_request(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, jdn_of(1900, 3, 1), 1'b0);
    queue_request(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, jdn_of(1600, 12, 31), 1'b0);
    queue_request(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, jdn_of(2024, 2, 29), 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      drain = (i % DRAIN_EVERY == 0);
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 4) != 0) begin
          queue_request(OP_DATE_TO_JDN, $urandom_range(1, 9999), $urandom_range(1, 12),
                        $urandom_range(1, 31), $urandom, drain);
        end else begin
          queue_request(OP_DATE_TO_JDN, $urandom, $urandom, $urandom, $urandom, drain);
        end
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          n = $urandom_range(FIRST_DAY, LAST_DAY);
        end else if (pick < 16) begin
          n = FIRST_DAY - 4 + $urandom_range(0, 8);
        end else if (pick < 18) begin
          n = LAST_DAY - 4 + $urandom_range(0, 8);
        end else begin
          n = $urandom;
        end
        queue_request(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, n, drain);
      end
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (calendar_requests_q.size() != 0 || calendar_results_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
